[rtl/csm_pkg.sv]
`default_nettype none
package csm_pkg;
    localparam int PARTICLES    = 1024;
    localparam int MAX_SLOTS    = 16;
    localparam int WALL_ID_BITS = 8;

    localparam int PART_BITS = $clog2(PARTICLES);
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int ROW_W     = CNT_W + MAX_SLOTS * WALL_ID_BITS;

    // result kinds
    localparam logic [1:0] KIND_MOVE     = 2'd0;
    localparam logic [1:0] KIND_ASSIGN   = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [9:0] particle;
        logic [7:0] wall_id;
        logic       empty_req;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] contact_index;
        logic [3:0] slot;
        logic [3:0] source_slot;
        logic       fresh;
        logic       done_res;
    } t_result;

    // queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_q_head;
endpackage
`default_nettype wire

[rtl/csm_ram.sv]
`default_nettype none
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/csm_front.sv]
`default_nettype none
module csm_front
    import csm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    input  wire logic     i_pop,
    output t_q_head       o_head,
    output logic          o_full
);
    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    // two-entry transaction queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_item;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];
    assign o_full       = (r_cnt == 2'd2);
endmodule
`default_nettype wire

[rtl/csm_back.sv]
`default_nettype none
module csm_back
    import csm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_head i_head,
    output logic         o_pop,
    output logic         o_clearing,
    output logic         o_valid,
    output t_result      o_result
);
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_COMP   = 3'd3;
    localparam logic [2:0] S_ASSIGN = 3'd4;
    localparam logic [2:0] S_WB     = 3'd5;

    logic [2:0]              r_state, n_state;
    logic [PART_BITS-1:0]    r_clr, n_clr;
    logic [PART_BITS-1:0]    r_p, n_p;
    logic [WALL_ID_BITS-1:0] r_lw [MAX_SLOTS];
    logic [WALL_ID_BITS-1:0] r_tab [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]    r_pres;
    logic [CNT_W-1:0]        r_lc, n_lc, r_n, r_nold, r_i;
    logic                    r_ovf, n_ovf;
    logic                    r_valid, n_valid;
    t_result                 r_res, n_res;

    logic                    ram_we;
    logic [PART_BITS-1:0]    ram_waddr, ram_raddr;
    logic [ROW_W-1:0]        ram_wdata, ram_rdata;

    t_in_item                hd;
    logic [PART_BITS-1:0]    hd_p;
    logic [WALL_ID_BITS-1:0] hd_wall;
    logic [CNT_W-1:0]        rd_cnt;
    logic [MAX_SLOTS-1:0]    rd_pres;
    logic [IDX_W-1:0]        ci, ni, nl;
    logic [WALL_ID_BITS-1:0] aw;
    logic                    hit;
    logic [IDX_W-1:0]        hit_m;
    logic [MAX_SLOTS*WALL_ID_BITS-1:0] tab_flat;

    assign hd      = i_head.item;
    assign hd_p    = hd.particle[PART_BITS-1:0];
    assign hd_wall = hd.wall_id[WALL_ID_BITS-1:0];
    assign ci      = r_i[IDX_W-1:0];
    assign ni      = r_n[IDX_W-1:0];
    assign nl      = ni - 1'b1;
    assign aw      = r_lw[ci];

    // rows hold the slot count above the packed wall ids
    csm_ram #(.WIDTH(ROW_W), .DEPTH(PARTICLES)) u_rows (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            tab_flat[s*WALL_ID_BITS +: WALL_ID_BITS] = r_tab[s];
        end
    end

    // slot count of the fetched row, clipped to the table size
    always_comb begin
        rd_cnt = ram_rdata[ROW_W-1 -: CNT_W];
        if (rd_cnt > CNT_W'(MAX_SLOTS)) begin
            rd_cnt = CNT_W'(MAX_SLOTS);
        end
    end

    // which fetched slots still have their wall in the loaded list
    always_comb begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
            rd_pres[s] = 1'b0;
            for (int m = 0; m < MAX_SLOTS; m++) begin
                if ((CNT_W'(m) < r_lc) &&
                    (r_lw[m] == ram_rdata[s*WALL_ID_BITS +: WALL_ID_BITS])) begin
                    rd_pres[s] = 1'b1;
                end
            end
        end
    end

    // first surviving slot holding the contact's wall
    always_comb begin
        hit   = 1'b0;
        hit_m = '0;
        for (int m = MAX_SLOTS - 1; m >= 0; m--) begin
            if ((CNT_W'(m) < r_nold) && (r_tab[m] == aw)) begin
                hit   = 1'b1;
                hit_m = IDX_W'(m);
            end
        end
    end

    // load step of the incoming item
    always_comb begin
        n_lc  = r_lc;
        n_ovf = r_ovf;
        if (r_lc < CNT_W'(MAX_SLOTS)) begin
            n_lc = r_lc + 1'b1;
        end else begin
            n_ovf = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_p       = r_p;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_p;
        ram_wdata = {r_n, tab_flat};
        ram_raddr = hd_p;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == PART_BITS'(PARTICLES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_p   = hd_p;
                    if (hd.empty_req) begin
                        ram_we    = 1'b1;
                        ram_waddr = hd_p;
                        ram_wdata = '0;
                    end else if (hd.last && !n_ovf) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:     n_state = S_COMP;
            S_COMP: begin
                if (r_i >= r_n) begin
                    n_state = S_ASSIGN;
                end
            end
            S_ASSIGN: begin
                if (r_i == r_lc - 1'b1) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // result strobe and payload
    always_comb begin
        n_valid = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                n_res          = '0;
                n_res.kind     = hd.empty_req ? KIND_CLEAR : KIND_OVERFLOW;
                n_res.done_res = 1'b1;
                n_valid        = i_head.valid && (hd.empty_req || (hd.last && n_ovf));
            end
            S_COMP: begin
                n_res = '0;
                if ((r_i < r_n) && !r_pres[ci]) begin
                    n_valid           = 1'b1;
                    n_res.kind        = KIND_MOVE;
                    n_res.slot        = 4'(ci);
                    n_res.source_slot = 4'(nl);
                end
            end
            S_ASSIGN: begin
                n_res               = '0;
                n_valid             = 1'b1;
                n_res.contact_index = 4'(ci);
                n_res.done_res      = (r_i == r_lc - 1'b1);
                if (hit) begin
                    n_res.kind = KIND_ASSIGN;
                    n_res.slot = 4'(hit_m);
                end else if (r_n < CNT_W'(MAX_SLOTS)) begin
                    n_res.kind  = KIND_ASSIGN;
                    n_res.slot  = 4'(ni);
                    n_res.fresh = 1'b1;
                end else begin
                    n_res.kind = KIND_OVERFLOW;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_lc    <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
            if (r_state == S_IDLE && i_head.valid) begin
                if (hd.empty_req) begin
                    r_lc  <= '0;
                    r_ovf <= 1'b0;
                end else if (!hd.last) begin
                    r_lc  <= n_lc;
                    r_ovf <= n_ovf;
                end else if (n_ovf) begin
                    r_lc  <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_lc <= n_lc;
                end
            end else if (r_state == S_WB) begin
                r_lc  <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // table, load list and result payload
    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_res <= n_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid && !hd.empty_req && (r_lc < CNT_W'(MAX_SLOTS))) begin
                    r_lw[r_lc[IDX_W-1:0]] <= hd_wall;
                end
            end
            S_RD: begin
                for (int s = 0; s < MAX_SLOTS; s++) begin
                    r_tab[s] <= ram_rdata[s*WALL_ID_BITS +: WALL_ID_BITS];
                end
                r_pres <= rd_pres;
                r_n    <= rd_cnt;
                r_i    <= '0;
            end
            S_COMP: begin
                if (r_i < r_n) begin
                    if (r_pres[ci]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        // move the last slot over the dropped one
                        r_tab[ci]  <= r_tab[nl];
                        r_pres[ci] <= r_pres[nl];
                        r_n        <= r_n - 1'b1;
                    end
                end else begin
                    r_nold <= r_n;
                    r_i    <= '0;
                end
            end
            S_ASSIGN: begin
                r_i <= r_i + 1'b1;
                if (!hit && (r_n < CNT_W'(MAX_SLOTS))) begin
                    // append a fresh slot
                    r_tab[ni] <= aw;
                    r_n       <= r_n + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_valid;
    assign o_result   = r_res;
endmodule
`default_nettype wire

[rtl/contact_slot_table_matcher_top.sv]
// Channel   Ports                    Handshake
// input     i_item (t_in_item)       taken when i_start && !o_busy
// result    o_result (t_result)      o_valid high for one cycle, always taken
//
// An intermediate contact is handled in the engine's idle state; an item ending a
// list goes through pop, row fetch, one compaction step per slot plus one to
// finish, one assignment per contact and row write back.
// After reset the row memory is cleared, one row per cycle, while o_busy is
// held high. A two-entry queue lets new items in while a list is worked off.
// Results cannot be held off by the receiver.
`default_nettype none
module contact_slot_table_matcher_top
    import csm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_item i_item,
    output logic          o_busy,
    output logic          o_valid,
    output t_result       o_result
);
    t_q_head q_head;
    logic    q_full, pop, clearing, push;

    assign o_busy = q_full || clearing;
    assign push   = i_start && !o_busy;

    csm_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (i_item),
        .i_pop  (pop),
        .o_head (q_head),
        .o_full (q_full)
    );

    csm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );
endmodule
`default_nettype wire

[rtl/csm_checker.sv]
`default_nettype none
module csm_checker
    import csm_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_busy,
    input wire logic     o_valid,
    input wire t_result  o_result
);
    // reset starts the row clearing sweep
    a_busy_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("not busy after reset");

    a_quiet_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result right after reset");

    a_clear_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == KIND_CLEAR |->
            o_result.done_res && o_result.slot == 4'd0 && !o_result.fresh)
        else $error("bad clear transaction");

    a_move_not_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == KIND_MOVE |-> !o_result.fresh && !o_result.done_res)
        else $error("bad move transaction");
endmodule

bind contact_slot_table_matcher_top csm_checker u_csm_checker (.*);
`default_nettype wire

[dv/contact_slot_table_matcher_checker.sv]
`default_nettype none
module contact_slot_table_matcher_checker
    import csm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_item i_item,
    input  wire logic     i_busy,
    input  wire logic     i_valid,
    input  wire t_result  i_result,
    output int            o_fail_count,
    output int            o_pending
);
    // shadow of the per-particle slot tables
    logic [4:0] slot_cnt [PARTICLES];
    logic [7:0] slot_wall [PARTICLES][MAX_SLOTS];
    logic [7:0] load_wall [MAX_SLOTS];
    int         load_cnt;
    bit         load_ovf;
    t_result    exp_results [$];
    int         mismatches;

    initial begin
        for (int p = 0; p < PARTICLES; p++) slot_cnt[p] = '0;
        load_cnt = 0;
        load_ovf = 0;
        mismatches = 0;
        o_pending = 0;
    end

    assign o_fail_count = mismatches;

    function automatic t_result mk(logic [1:0] kind, int cidx, int slot, int src,
                                   bit fresh);
        t_result r;
        r.kind = kind;
        r.contact_index = cidx[3:0];
        r.slot = slot[3:0];
        r.source_slot = src[3:0];
        r.fresh = fresh;
        r.done_res = 1'b0;
        return r;
    endfunction

    // predict the results of one accepted transaction
    task automatic predict_contacts(t_in_item it);
        int p, n, iold, nold, m, first;
        bit hit;
        p = int'(it.particle) % PARTICLES;
        first = exp_results.size();
        if (it.empty_req) begin
            slot_cnt[p] = '0;
            load_cnt = 0;
            load_ovf = 0;
            exp_results.push_back(mk(KIND_CLEAR, 0, 0, 0, 0));
        end else begin
            if (load_cnt < MAX_SLOTS) begin
                load_wall[load_cnt] = it.wall_id;
                load_cnt++;
            end else begin
                load_ovf = 1;
            end
            if (it.last && load_ovf) begin
                exp_results.push_back(mk(KIND_OVERFLOW, 0, 0, 0, 0));
                load_cnt = 0;
                load_ovf = 0;
            end else if (it.last) begin
                n = slot_cnt[p];
                // compaction: replace vanished walls with the last slot
                iold = 0;
                while (iold < n) begin
                    hit = 0;
                    for (m = 0; m < load_cnt; m++)
                        if (load_wall[m] == slot_wall[p][iold]) hit = 1;
                    if (!hit) begin
                        slot_wall[p][iold] = slot_wall[p][n-1];
                        exp_results.push_back(mk(KIND_MOVE, 0, iold, n - 1, 0));
                        n--;
                    end else begin
                        iold++;
                    end
                end
                // assignment against survivors, append new walls
                nold = n;
                for (int c = 0; c < load_cnt; c++) begin
                    m = 0;
                    while (m < nold && slot_wall[p][m] != load_wall[c]) m++;
                    if (m < nold) begin
                        exp_results.push_back(mk(KIND_ASSIGN, c, m, 0, 0));
                    end else if (n < MAX_SLOTS) begin
                        slot_wall[p][n] = load_wall[c];
                        exp_results.push_back(mk(KIND_ASSIGN, c, n, 0, 1));
                        n++;
                    end else begin
                        exp_results.push_back(mk(KIND_OVERFLOW, c, 0, 0, 0));
                    end
                end
                slot_cnt[p] = n[4:0];
                load_cnt = 0;
                load_ovf = 0;
            end
        end
        if (exp_results.size() > first)
            exp_results[exp_results.size()-1].done_res = 1'b1;
    endtask

    // watch both channels
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_start && !i_busy) predict_contacts(i_item);
        if (i_rst_n && i_valid) begin
            if (exp_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", i_result);
            end else begin
                want = exp_results.pop_front();
                if (want.kind !== i_result.kind
                        || want.contact_index !== i_result.contact_index
                        || want.slot !== i_result.slot
                        || want.source_slot !== i_result.source_slot
                        || want.fresh !== i_result.fresh
                        || want.done_res !== i_result.done_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, i_result);
                end
            end
        end
        o_pending = exp_results.size();
    end
endmodule
`default_nettype wire

[dv/contact_slot_table_matcher_top_tb.sv]
`default_nettype none
module contact_slot_table_matcher_top_tb;
    import csm_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    t_in_item item = '0;
    logic     busy;
    logic     valid;
    t_result  result;
    int       fail_count;
    int       pending;
    int       cycles = 0;
    bit       calm = 0;

    localparam int CYCLE_LIMIT = 400000;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    contact_slot_table_matcher_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_item(item),
        .o_busy(busy), .o_valid(valid), .o_result(result)
    );

    contact_slot_table_matcher_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_item(item),
        .i_busy(busy), .i_valid(valid), .i_result(result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("contact_slot_table_matcher_top regression: fail");
            $finish;
        end
    end

    // send one transaction, with an optional random gap first
    task automatic send_contact(int part, int wall, bit empty, bit lst);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{particle: part[9:0], wall_id: wall[7:0], empty_req: empty, last: lst};
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // one list of walls for a particle, drawn from a small wall pool when pool is nonzero
    task automatic send_list(int part, int len, int pool);
        for (int i = 0; i < len; i++)
            send_contact(part, (pool > 0) ? $urandom_range(0, pool) : $urandom_range(0, 255),
                         0, i == len - 1);
    endtask

    initial begin
        int part, len, sent, r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, single contacts, full table, overflow, clear
        send_contact(0, 0, 0, 1);
        send_contact(1023, 255, 0, 1);
        send_contact(1023, 255, 0, 0);
        send_contact(1023, 7, 0, 1);
        for (int i = 0; i < 16; i++) send_contact(5, i, 0, i == 15);
        for (int i = 0; i < 17; i++) send_contact(6, i, 0, i == 16);
        send_contact(5, 3, 0, 0);
        send_contact(5, 3, 0, 1);
        send_contact(5, 0, 1, 0);
        send_contact(1023, 9, 0, 0);
        send_contact(1023, 0, 1, 1);
        send_contact(0, 170, 0, 0);
        send_contact(512, 85, 0, 1);
        // random: mostly well-formed lists on a few particles
        sent = 0;
        while (sent < 136) begin
            if (sent > 105) calm = 1;
            part = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, 3);
            r = $urandom_range(0, 19);
            if (r == 0) begin
                send_contact(part, $urandom_range(0, 255), 1, $urandom_range(0, 1));
                sent++;
            end else if (r == 1) begin
                len = $urandom_range(17, 19);
                send_list(part, len, 0);
                sent += len;
            end else begin
                len = $urandom_range(1, 8);
                if (r == 2) len = $urandom_range(10, 16);
                send_list(part, len, (r < 10) ? 12 : 0);
                sent += len;
            end
        end
        start <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("contact_slot_table_matcher_top regression: pass");
        end else begin
            $display("contact_slot_table_matcher_top regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/csm_pkg.sv
rtl/csm_ram.sv
rtl/csm_front.sv
rtl/csm_back.sv
rtl/contact_slot_table_matcher_top.sv
rtl/csm_checker.sv
dv/contact_slot_table_matcher_checker.sv
dv/contact_slot_table_matcher_top_tb.sv
